[rtl/shcexp_pkg.sv]
// ----------------------------------------------------------------------------
// shcexp_pkg
// Float helpers and constants for the sinh/cosh pipeline: single-precision
// multiply and add with round-to-nearest-even, floor and small int-to-float.
// ----------------------------------------------------------------------------
`default_nettype none

package shcexp_pkg;

	// Pipeline depth
	localparam int NST = 14;

	// Single-precision constants
	localparam logic [31:0] F_P87   = 32'h42AE0000;
	localparam logic [31:0] F_M87   = 32'hC2AE0000;
	localparam logic [31:0] F_LOG2E = 32'h3FB8AA3B;
	localparam logic [31:0] F_C1    = 32'h3F317218;
	localparam logic [31:0] F_C2    = 32'h3E75FDF0;
	localparam logic [31:0] F_C3    = 32'h3D635847;
	localparam logic [31:0] F_C4    = 32'h3C1D955B;
	localparam logic [31:0] F_ONE   = 32'h3F800000;
	localparam logic [31:0] F_HALF  = 32'h3F000000;
	localparam logic [7:0]  EXP_BIAS = 8'd127;

	// Per-lane pipeline payload
	typedef struct packed {
		logic [31:0] acc;
		logic [31:0] frac;
		logic [7:0]  n;
	} lane_t;

	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] c;
		logic       f;
		c = '0;
		f = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (v[i]) f = 1'b1;
			else if (!f) c = c + 6'd1;
		end
		return c;
	endfunction

	function automatic logic [4:0] clz27(input logic [26:0] v);
		logic [4:0] c;
		logic       f;
		c = '0;
		f = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (v[i]) f = 1'b1;
			else if (!f) c = c + 5'd1;
		end
		return c;
	endfunction

	// Clamp to +-87; NaN goes by its sign bit
	function automatic logic [31:0] fclamp(input logic [31:0] b);
		if (b[30:0] > F_P87[30:0]) return b[31] ? F_M87 : F_P87;
		return b;
	endfunction

	// Float multiply, finite operands, RNE, subnormals handled
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic              s;
		logic [7:0]        ea, eb, ef;
		logic [23:0]       ma, mb;
		logic [47:0]       p, pn, m;
		logic [5:0]        lz;
		logic signed [10:0] e;
		logic [5:0]        sh;
		logic              st, inc;
		logic [30:0]       raw;
		s  = a[31] ^ b[31];
		ea = {a[30:24], a[23] | ~|a[30:23]};
		eb = {b[30:24], b[23] | ~|b[30:23]};
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		p  = ma * mb;
		if (p == '0) return {s, 31'b0};
		lz = clz48(p);
		pn = p << lz;
		e  = 11'(ea) + 11'(eb) - 11'(lz) - 11'd126;
		if (e > 11'sd254) return {s, 8'hFF, 23'b0};
		if (e < -11'sd46) sh = 6'd48;
		else if (e < 11'sd1) sh = 6'(11'sd1 - e);
		else sh = '0;
		m   = pn >> sh;
		st  = |(pn & ~({48{1'b1}} << sh));
		ef  = (e < 11'sd1) ? 8'd0 : e[7:0];
		inc = m[23] & (st | (|m[22:0]) | m[24]);
		raw = {ef, m[46:24]} + 31'(inc);
		return {s, raw};
	endfunction

	// Float add, finite operands, RNE, subnormals handled
	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x, y;
		logic [7:0]  ex, ey, d, shl;
		logic [26:0] ax, yf, ys, n;
		logic [27:0] s28;
		logic [4:0]  lz;
		logic [8:0]  e;
		logic [7:0]  ef;
		logic        inc;
		logic [30:0] raw;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = {x[30:24], x[23] | ~|x[30:23]};
		ey = {y[30:24], y[23] | ~|y[30:23]};
		ax = {|x[30:23], x[22:0], 3'b0};
		yf = {|y[30:23], y[22:0], 3'b0};
		d  = ex - ey;
		if (d >= 8'd27) begin
			ys = {26'b0, |yf};
		end else begin
			ys = yf >> d;
			ys[0] = ys[0] | (|(yf & ~({27{1'b1}} << d)));
		end
		if (x[31] ^ y[31]) s28 = {1'b0, ax} - {1'b0, ys};
		else s28 = {1'b0, ax} + {1'b0, ys};
		if (s28 == '0) return {x[31] & y[31], 31'b0};
		if (s28[27]) begin
			n = {s28[27:2], s28[1] | s28[0]};
			e = 9'(ex) + 9'd1;
		end else begin
			lz  = clz27(s28[26:0]);
			shl = (8'(lz) > ex - 8'd1) ? ex - 8'd1 : 8'(lz);
			n   = s28[26:0] << shl;
			e   = 9'(ex - shl);
		end
		if (e > 9'd254) return {x[31], 8'hFF, 23'b0};
		ef  = n[26] ? e[7:0] : 8'd0;
		inc = n[2] & (n[1] | n[0] | n[3]);
		raw = {ef, n[25:3]} + 31'(inc);
		return {x[31], raw};
	endfunction

	// Floor of a float known to lie within +-126
	function automatic logic [7:0] ffloor(input logic [31:0] v);
		logic [7:0]  ip, sh;
		logic        fnz;
		logic [23:0] m;
		m = {1'b1, v[22:0]};
		if (v[30:23] < EXP_BIAS) begin
			ip  = '0;
			fnz = |v[30:0];
		end else begin
			sh  = 8'd150 - v[30:23];
			ip  = 8'(m >> sh);
			fnz = |(m & ~({24{1'b1}} << sh));
		end
		return v[31] ? 8'(-(ip + 8'(fnz))) : ip;
	endfunction

	// Exact float of a signed 8-bit integer
	function automatic logic [31:0] i2f(input logic [7:0] n);
		logic [7:0]  mag;
		logic [2:0]  p;
		logic [23:0] t;
		if (n == '0) return '0;
		mag = n[7] ? 8'(-n) : n;
		p   = '0;
		for (int i = 0; i < 8; i++) begin
			if (mag[i]) p = 3'(i);
		end
		t = 24'(mag) << (5'd23 - 5'(p));
		return {n[7], EXP_BIAS + 8'(p), t[22:0]};
	endfunction

endpackage

`default_nettype wire

[rtl/sinh_cosh_via_fast_exp_top.sv]
// ----------------------------------------------------------------------------
// sinh_cosh_via_fast_exp_top
// Single-precision sinh and cosh from two fast exp approximations.
// ----------------------------------------------------------------------------
// One argument beat enters per clock while in_ready is high, and its sinh/cosh
// beat leaves from the last stage; throughput is one beat per cycle when the
// output side keeps taking beats. Each of the 14 stages does about one float
// operation (a multiply, an add, or the floor and int-to-float split), two lanes
// side by side for exp(x) and exp(-x). A stage holds when the one after it is
// full and stalled, so bubbles close up and input keeps flowing while a result
// waits on the output, until the pipeline is full.
`default_nettype none

module sinh_cosh_via_fast_exp_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] arg_bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      sinh_bits,
	output logic [31:0]      cosh_bits
);
	import shcexp_pkg::*;

	// Stage work for one lane, stages one through twelve
	function automatic lane_t step(input int k, input lane_t in);
		lane_t o;
		o = in;
		unique case (k)
			1: o.acc = fmul(fclamp(in.acc), F_LOG2E);
			2: begin
				o.n    = ffloor(in.acc);
				o.frac = i2f(o.n);
			end
			3: o.frac = fadd(in.acc, {~in.frac[31], in.frac[30:0]});
			4: o.acc = fmul(in.frac, F_C4);
			5: o.acc = fadd(F_C3, in.acc);
			6, 8, 10: o.acc = fmul(in.frac, in.acc);
			7: o.acc = fadd(F_C2, in.acc);
			9: o.acc = fadd(F_C1, in.acc);
			11: o.acc = fadd(F_ONE, in.acc);
			12: o.acc = fmul({1'b0, in.n + EXP_BIAS, 23'b0}, in.acc);
			default: o = in;
		endcase
		return o;
	endfunction

	lane_t       pos_s [1:NST];
	lane_t       neg_s [1:NST];
	lane_t       pos_d [1:NST];
	lane_t       neg_d [1:NST];
	logic [NST:1] vld_s;
	logic [NST:1] en;

	// Stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en[NST] = !vld_s[NST] || out_ready;
		for (int k = NST - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k + 1];
		end
	end

	// Next-stage data
	always_comb begin
		lane_t p0, n0;
		p0 = '{acc: arg_bits, frac: '0, n: '0};
		n0 = '{acc: {~arg_bits[31], arg_bits[30:0]}, frac: '0, n: '0};
		pos_d[1] = step(1, p0);
		neg_d[1] = step(1, n0);
		for (int k = 2; k <= 12; k++) begin
			pos_d[k] = step(k, pos_s[k - 1]);
			neg_d[k] = step(k, neg_s[k - 1]);
		end
		// difference and sum of the two exponentials
		pos_d[13] = pos_s[12];
		neg_d[13] = neg_s[12];
		pos_d[13].acc = fadd(pos_s[12].acc, {~neg_s[12].acc[31], neg_s[12].acc[30:0]});
		neg_d[13].acc = fadd(pos_s[12].acc, neg_s[12].acc);
		// halve both
		pos_d[14] = pos_s[13];
		neg_d[14] = neg_s[13];
		pos_d[14].acc = fmul(F_HALF, pos_s[13].acc);
		neg_d[14].acc = fmul(F_HALF, neg_s[13].acc);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k - 1];
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		for (int k = 1; k <= NST; k++) begin
			if (en[k]) begin
				pos_s[k] <= pos_d[k];
				neg_s[k] <= neg_d[k];
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NST];
	assign sinh_bits = pos_s[NST].acc;
	assign cosh_bits = neg_s[NST].acc;

endmodule

`default_nettype wire
